/* hdl/rrc_pkg.sv */
// rom region checksum shared types and constants
package rrc_pkg;

    localparam int ADDR_W  = 20;
    localparam int DATA_W  = 8;
    localparam int SUM_W   = 16;
    localparam int SIZE_W  = 21;
    localparam int CODE_W  = 4;
    localparam int LOW_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'd1;

    localparam logic [CODE_W-1:0] RANGE_CODE_RESET = 4'hC;

    localparam logic [CODE_W-1:0] CODE_HI_256K  = 4'h0;
    localparam logic [CODE_W-1:0] CODE_HI_512K  = 4'h1;
    localparam logic [CODE_W-1:0] CODE_HI_1M    = 4'h2;
    localparam logic [CODE_W-1:0] CODE_LO_8K    = 4'hA;
    localparam logic [CODE_W-1:0] CODE_LO_16K   = 4'hB;
    localparam logic [CODE_W-1:0] CODE_LO_32K   = 4'hC;
    localparam logic [CODE_W-1:0] CODE_LO_48K   = 4'hD;
    localparam logic [CODE_W-1:0] CODE_HI_64K   = 4'hE;
    localparam logic [CODE_W-1:0] CODE_HI_128K  = 4'hF;

    localparam logic [LOW_W-1:0] LOW_SMALL   = 16'h1FEF;
    localparam logic [LOW_W-1:0] LOW_MEDIUM  = 16'h3FEF;
    localparam logic [LOW_W-1:0] LOW_DEFAULT = 16'h7FEF;
    localparam logic [LOW_W-1:0] LOW_LARGE   = 16'hBFEF;

    localparam logic [ADDR_W-1:0] HIGH_START  = 20'h08000;
    localparam logic [ADDR_W-1:0] HIGH_64K    = 20'h0FFFF;
    localparam logic [ADDR_W-1:0] HIGH_128K   = 20'h1FFFF;
    localparam logic [ADDR_W-1:0] HIGH_256K   = 20'h3FFFF;
    localparam logic [ADDR_W-1:0] HIGH_512K   = 20'h7FFFF;
    localparam logic [ADDR_W-1:0] HIGH_1M     = 20'hFFFFF;

    localparam logic [SIZE_W-1:0] SIZE_SPLIT  = 21'h04000;

    typedef struct packed {
        logic [LOW_W-1:0]  low_end;
        logic [ADDR_W-1:0] high_end;
        logic              high_en;
    } region_t;

endpackage

/* hdl/rrc_region.sv */
// region bounds decode from range code and image size
module rrc_region
    import rrc_pkg::*;
(
    input  logic [CODE_W-1:0] range_code,
    input  logic [SIZE_W-1:0] image_size,
    output region_t           region
);

    logic [LOW_W-1:0]  lo_raw;
    logic [ADDR_W-1:0] hi_raw;
    logic              hi_raw_en;
    logic              size_set;

    always_comb
    begin
        lo_raw    = LOW_DEFAULT;
        hi_raw    = '0;
        hi_raw_en = 1'b0;
        unique case (range_code)
            CODE_LO_8K:   lo_raw = LOW_SMALL;
            CODE_LO_16K:  lo_raw = LOW_MEDIUM;
            CODE_LO_32K:  lo_raw = LOW_DEFAULT;
            CODE_LO_48K:  lo_raw = LOW_LARGE;
            CODE_HI_64K:
            begin
                hi_raw    = HIGH_64K;
                hi_raw_en = 1'b1;
            end
            CODE_HI_128K:
            begin
                hi_raw    = HIGH_128K;
                hi_raw_en = 1'b1;
            end
            CODE_HI_256K:
            begin
                hi_raw    = HIGH_256K;
                hi_raw_en = 1'b1;
            end
            CODE_HI_512K:
            begin
                hi_raw    = HIGH_512K;
                hi_raw_en = 1'b1;
            end
            CODE_HI_1M:
            begin
                hi_raw    = HIGH_1M;
                hi_raw_en = 1'b1;
            end
            default:
            begin
                lo_raw    = LOW_DEFAULT;
                hi_raw_en = 1'b0;
            end
        endcase
    end

    assign size_set = (image_size != '0);

    always_comb
    begin
        region.low_end  = lo_raw;
        region.high_end = hi_raw;
        region.high_en  = hi_raw_en;
        if (size_set && ({{(SIZE_W-LOW_W){1'b0}}, lo_raw} >= image_size))
        begin
            region.low_end = (image_size >= SIZE_SPLIT) ? LOW_MEDIUM : LOW_SMALL;
        end
        if (size_set && ({{(SIZE_W-ADDR_W){1'b0}}, hi_raw} >= image_size))
        begin
            region.high_en = 1'b0;
        end
    end

endmodule

/* hdl/rom_region_checksum_top.sv */
// rom region checksum top level: input register, region test, sum and result register
//
//  channel   signals                                        direction
//  in        in_valid/in_ready, byte_address, data_byte,    into block
//            end_of_image
//  out       out_valid/out_ready, checksum                  out of block
//  cfg       cfg_write_en, cfg_index, cfg_data              into block
//
//  one item per cycle unless a held result stalls a last item; a last item's result
//  reaches the output register through the input register, then region compare and add
//  reset clears the sum and valid flags and sets the config registers (range code 0xC, size 0)
//  a held result only stalls a following last item; other items keep flowing
module rom_region_checksum_top
    import rrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_W-1:0]    byte_address,
    input  logic [DATA_W-1:0]    data_byte,
    input  logic                 end_of_image,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SUM_W-1:0]     checksum,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    logic [CODE_W-1:0] range_code_reg;
    logic [SIZE_W-1:0] image_size_reg;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic              s1_last_reg;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;

    region_t           region;
    logic              take;
    logic              out_free;
    logic              s1_advance;

    rrc_region u_region (
        .range_code (range_code_reg),
        .image_size (image_size_reg),
        .region     (region)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_code_reg <= RANGE_CODE_RESET;
            image_size_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_RANGE_CODE: range_code_reg <= cfg_data[CODE_W-1:0];
                CFG_IMAGE_SIZE: image_size_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign take = (s1_addr_reg <= {{(ADDR_W-LOW_W){1'b0}}, region.low_end})
                || (region.high_en && (s1_addr_reg >= HIGH_START)
                    && (s1_addr_reg <= region.high_end));

    assign sum_next   = sum_reg + (take ? {{(SUM_W-DATA_W){1'b0}}, s1_data_reg} : '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_addr_reg <= byte_address;
            s1_data_reg <= data_byte;
            s1_last_reg <= end_of_image;
        end
    end

    // running sum and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                sum_reg <= s1_last_reg ? '0 : sum_next;
            end
            if (s1_advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            out_sum_reg <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = out_sum_reg;

endmodule
